FILE: sv/ultrasonic_echo_ranger_defines.svh
// Assertion macros used by the ultrasonic echo ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define UER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ultrasonic echo ranger: assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ultrasonic echo ranger: assertion failed");

`endif

FILE: sv/uer_pkg.sv
// Shared types, constants and phase codes of the ultrasonic echo ranger.
package uer_pkg;

    // Field widths
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 10;
    localparam int STATUS_W = 2;
    localparam int DIST_W   = 14;
    // Echo limit holds max_distance_cm times up to 256 ticks per centimetre.
    localparam int LIMIT_W  = 18;
    // Beat widths on the stream ports
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Default timing, in microsecond ticks, and the reset range in centimetres
    localparam int unsigned TRIG_LOW_US_DEF  = 4;
    localparam int unsigned TRIG_HIGH_US_DEF = 10;
    localparam int unsigned ECHO_WAIT_US_DEF = 1000;
    localparam int unsigned US_PER_CM_DEF    = 58;
    localparam int unsigned MAX_DIST_RESET   = 400;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ECHO  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd3;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Measurement phases
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LOW     = 6'b000010,
        PH_HIGH    = 6'b000100,
        PH_CHECK   = 6'b001000,
        PH_WAIT    = 6'b010000,
        PH_MEASURE = 6'b100000
    } phase_t;

    // One sampled tick
    typedef struct packed {
        logic echo_level;
        logic start_req;
    } tick_t;

    // One result beat
    typedef struct packed {
        logic [DIST_W-1:0]   distance_sixteenths;
        logic [STATUS_W-1:0] status;
        logic                done_res;
        logic                trigger_level;
    } result_t;

endpackage

FILE: sv/uer_in_reg.sv
// Input register that captures one sampled tick per beat.
module uer_in_reg
    import uer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                advance,
    output logic                item_valid,
    output tick_t               item
);

    logic  valid_reg;
    tick_t item_reg;

    // The register frees up when empty or when its tick moves on this cycle.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload, loaded on an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.start_req  <= s_tdata[0];
            item_reg.echo_level <= s_tdata[1];
        end
    end

endmodule

FILE: sv/uer_step.sv
// Measurement sequencer: phase and tick counter, and the result of one tick.
module uer_step
    import uer_pkg::*;
#(
    parameter int unsigned TRIG_LOW_US  = TRIG_LOW_US_DEF,
    parameter int unsigned TRIG_HIGH_US = TRIG_HIGH_US_DEF,
    parameter int unsigned ECHO_WAIT_US = ECHO_WAIT_US_DEF,
    parameter int unsigned US_PER_CM    = US_PER_CM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  tick_t              item,
    input  logic [LIMIT_W-1:0] echo_limit,
    output result_t            res_next
);

    // Division by US_PER_CM as a multiply by a rounded-up reciprocal.
    // With DIV_K = NUM_W + ceil(log2(US_PER_CM)) the quotient is exact
    // for every numerator below 2**NUM_W.
    localparam int NUM_W   = CNT_W + 4;
    localparam int DIV_K   = NUM_W + $clog2(US_PER_CM);
    localparam int RECIP_W = NUM_W + 2;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_K) + US_PER_CM - 1) / US_PER_CM;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cnt_inc, cnt_sat;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quo;
    logic [DIST_W-1:0] dist_sat;

    // Counter helpers: wrapping and saturating increment
    assign cnt_inc = count_reg + CNT_W'(1);
    assign cnt_sat = (count_reg == CNT_MAX) ? count_reg : cnt_inc;

    // Range in sixteenths of a centimetre, saturated to the field width
    assign prod     = PROD_W'({count_reg, 4'b0000}) * PROD_W'(RECIP);
    assign quo      = prod >> DIV_K;
    assign dist_sat = (quo > PROD_W'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];

    // Next phase, next count and this tick's result
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        res_next   = '0;
        case (phase_reg)
            PH_LOW:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= CNT_W'(TRIG_LOW_US))
                begin
                    phase_next = PH_HIGH;
                    count_next = '0;
                end
            end
            PH_HIGH:
            begin
                res_next.trigger_level = 1'b1;
                count_next = cnt_inc;
                if (cnt_inc >= CNT_W'(TRIG_HIGH_US))
                begin
                    phase_next = PH_CHECK;
                    count_next = '0;
                end
            end
            PH_CHECK:
            begin
                if (item.echo_level)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = STATUS_BUSY;
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (item.echo_level)
                begin
                    count_next = CNT_W'(1);
                    phase_next = PH_MEASURE;
                    // A zero limit fails on the first high tick.
                    if (echo_limit == '0)
                    begin
                        res_next.done_res = 1'b1;
                        res_next.status   = STATUS_TOO_LONG;
                        phase_next        = PH_IDLE;
                    end
                end
                else
                begin
                    count_next = cnt_sat;
                    if (cnt_sat >= CNT_W'(ECHO_WAIT_US))
                    begin
                        res_next.done_res = 1'b1;
                        res_next.status   = STATUS_NO_ECHO;
                        phase_next        = PH_IDLE;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (item.echo_level)
                begin
                    count_next = cnt_sat;
                    if ((LIMIT_W'(cnt_sat) >= echo_limit) || (cnt_sat == CNT_MAX))
                    begin
                        res_next.done_res = 1'b1;
                        res_next.status   = STATUS_TOO_LONG;
                        phase_next        = PH_IDLE;
                    end
                end
                else
                begin
                    res_next.done_res            = 1'b1;
                    res_next.status              = STATUS_OK;
                    res_next.distance_sixteenths = dist_sat;
                    phase_next                   = PH_IDLE;
                end
            end
            default:
            begin
                // Idle, and any code that means nothing, waits for a start.
                phase_next = PH_IDLE;
                if (item.start_req)
                begin
                    count_next = CNT_W'(1);
                    if (CNT_W'(1) >= CNT_W'(TRIG_LOW_US))
                    begin
                        phase_next = PH_HIGH;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_LOW;
                    end
                end
            end
        endcase
    end

    // State registers, moved once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/uer_out_reg.sv
// Result register that holds one result beat until the sink takes it.
module uer_out_reg
    import uer_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             res_next,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    // A new result may enter when the register is empty or being emptied.
    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: sv/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: one sampled microsecond tick in, one result beat out.
//
// Each input beat is one microsecond tick carrying a start request and the
// sampled echo level; each tick yields exactly one result beat with the
// trigger pin level, a done flag, a status and the range in sixteenths of a
// centimetre. The block takes one tick every clock cycle while the result beat
// is not stalled: a tick is registered in the input register, passes through
// the sequencer logic and is registered in the result register. A stalled
// result beat holds the next tick in the input register, and with both
// registers full the input stalls. The echo limit is max_distance_cm times
// US_PER_CM, loaded into a register on the configuration write beat, so
// write it only while no measurement is running.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int unsigned TRIG_LOW_US  = TRIG_LOW_US_DEF,
    parameter int unsigned TRIG_HIGH_US = TRIG_HIGH_US_DEF,
    parameter int unsigned ECHO_WAIT_US = ECHO_WAIT_US_DEF,
    parameter int unsigned US_PER_CM    = US_PER_CM_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: max_distance_cm
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    // Ticks in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] start_req, [1] echo_level, rest zero
    // Results out
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] trigger_level, [1] done_res,
                                           // [3:2] status, [17:4] distance_sixteenths
);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_DIST_RESET * US_PER_CM);

    logic               cfg_write;
    logic [LIMIT_W-1:0] echo_limit_reg, echo_limit_next;
    logic               advance;
    logic               item_valid;
    logic               step_en;
    tick_t              item;
    result_t            res_next;

    // Configuration is always taken; the limit is kept premultiplied.
    assign cfg_ready       = 1'b1;
    assign echo_limit_next = LIMIT_W'(cfg_data) * LIMIT_W'(US_PER_CM);
    assign cfg_write       = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            echo_limit_reg <= echo_limit_next;
        end
    end

    // A held tick is processed whenever the result register can take it.
    assign step_en = item_valid && advance;

    uer_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    uer_step #(
        .TRIG_LOW_US  (TRIG_LOW_US),
        .TRIG_HIGH_US (TRIG_HIGH_US),
        .ECHO_WAIT_US (ECHO_WAIT_US),
        .US_PER_CM    (US_PER_CM)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .item       (item),
        .echo_limit (echo_limit_reg),
        .res_next   (res_next)
    );

    uer_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_valid),
        .res_next (res_next),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/uer_checker.sv
// Port-level checks on the result beats of the ultrasonic echo ranger.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker
    import uer_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result beat keeps its contents.
    `UER_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Without done, status and distance stay zero, and so does the padding.
    `UER_ASSERT_NOW(a_idle_fields, m_tvalid && !m_tdata[1], m_tdata[23:2] == 22'd0)

    // A failed measurement carries no distance.
    `UER_ASSERT_NOW(a_fail_no_dist, m_tvalid && (m_tdata[3:2] != STATUS_OK), m_tdata[17:4] == 14'd0)

    // The trigger pulse never coincides with the end of a measurement.
    `UER_ASSERT_NOW(a_trig_not_done, m_tvalid && m_tdata[0], !m_tdata[1])

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/ultrasonic_echo_ranger_tb.sv
// Self-checking testbench of the ultrasonic echo ranger, with its own tick-by-tick predictor.
module ultrasonic_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned TRIG_TICKS   = TRIG_LOW_US_DEF + TRIG_HIGH_US_DEF;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned STUCK_LIMIT  = 4000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_SETTLE = 8;
    localparam int unsigned CFG_SETTLE   = 4;
    localparam int unsigned PHASE_TICKS  = 60;

    // One tick waiting to be sent, with a flag that suppresses the sender's gap after it.
    typedef struct packed {
        logic no_gap;
        logic echo_level;
        logic start_req;
    } tick_item_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // [0] start_req, [1] echo_level, rest zero
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [0] trigger_level, [1] done_res,
                                          // [3:2] status, [17:4] distance_sixteenths

    tick_item_t  pending_ticks[$];
    result_t     expected_results[$];

    // Predicted state of the ranger and its copy of the range register.
    phase_t            ranger_phase = PH_IDLE;
    logic [CNT_W-1:0]  ranger_count = '0;
    logic [CFG_W-1:0]  range_cm     = CFG_W'(MAX_DIST_RESET);

    int unsigned tx_wait        = 0;
    int unsigned rx_wait        = 0;
    int unsigned rx_burst       = 0;
    int unsigned rx_hold_left   = 0;
    int unsigned rx_hold_asks   = 0;
    int unsigned rx_hold_served = 0;
    logic        rx_quiet       = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned stuck_cycles   = 0;

    ultrasonic_echo_ranger i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the predicted ranger by one tick and return the result beat it yields.
    function automatic result_t advance_ranger(input logic start, input logic echo);
        result_t     res;
        int unsigned limit;
        int unsigned span;
        res   = '0;
        limit = range_cm * US_PER_CM_DEF;
        case (ranger_phase)
            PH_LOW:
            begin
                ranger_count = ranger_count + 1'b1;
                if (ranger_count >= TRIG_LOW_US_DEF)
                begin
                    ranger_phase = PH_HIGH;
                    ranger_count = '0;
                end
            end
            PH_HIGH:
            begin
                res.trigger_level = 1'b1;
                ranger_count      = ranger_count + 1'b1;
                if (ranger_count >= TRIG_HIGH_US_DEF)
                begin
                    ranger_phase = PH_CHECK;
                    ranger_count = '0;
                end
            end
            PH_CHECK:
            begin
                // Echo still high from an earlier ping: give up at once.
                if (echo)
                begin
                    res.done_res = 1'b1;
                    res.status   = STATUS_BUSY;
                    ranger_phase = PH_IDLE;
                end
                else
                begin
                    ranger_phase = PH_WAIT;
                    ranger_count = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    ranger_count = CNT_W'(1);
                    ranger_phase = PH_MEASURE;
                    // A zero range fails on the very first high tick.
                    if (ranger_count >= limit)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_TOO_LONG;
                        ranger_phase = PH_IDLE;
                    end
                end
                else
                begin
                    if (ranger_count != CNT_MAX)
                        ranger_count = ranger_count + 1'b1;
                    if (ranger_count >= ECHO_WAIT_US_DEF)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_NO_ECHO;
                        ranger_phase = PH_IDLE;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (echo)
                begin
                    if (ranger_count != CNT_MAX)
                        ranger_count = ranger_count + 1'b1;
                    if (ranger_count >= limit || ranger_count == CNT_MAX)
                    begin
                        res.done_res = 1'b1;
                        res.status   = STATUS_TOO_LONG;
                        ranger_phase = PH_IDLE;
                    end
                end
                else
                begin
                    span = ranger_count * 32'd16 / US_PER_CM_DEF;
                    res.distance_sixteenths = (span > DIST_MAX) ? DIST_MAX : span[DIST_W-1:0];
                    res.done_res = 1'b1;
                    res.status   = STATUS_OK;
                    ranger_phase = PH_IDLE;
                end
            end
            default:
            begin
                // Idle: the start tick itself is the first low trigger tick.
                ranger_phase = PH_IDLE;
                if (start)
                begin
                    ranger_count = CNT_W'(1);
                    if (ranger_count >= TRIG_LOW_US_DEF)
                    begin
                        ranger_phase = PH_HIGH;
                        ranger_count = '0;
                    end
                    else
                    begin
                        ranger_phase = PH_LOW;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void queue_ticks(input logic start, input logic echo, input int unsigned n,
                                        input logic no_gap);
        tick_item_t t;
        t.start_req  = start;
        t.echo_level = echo;
        t.no_gap     = no_gap;
        repeat (n) pending_ticks.push_back(t);
    endfunction

    // One ranging cycle: trigger ticks, the check tick, low wait ticks, high echo ticks, the end.
    function automatic void queue_ranging(input logic chk_echo, input int unsigned wait_n,
                                          input int unsigned high_n, input logic keep_start,
                                          input logic stray, input logic no_gap);
        int unsigned k;
        queue_ticks(1'b1, 1'b0, 1, no_gap);
        for (k = 1; k < TRIG_TICKS; k++)
        begin
            if (stray)
                queue_ticks($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 1, no_gap);
            else
                queue_ticks(keep_start, 1'b0, 1, no_gap);
        end
        queue_ticks(keep_start, chk_echo, 1, no_gap);
        queue_ticks(keep_start, 1'b0, wait_n, no_gap);
        queue_ticks(keep_start, 1'b1, high_n, no_gap);
        queue_ticks(keep_start & ~chk_echo, 1'b0, 1, no_gap);
        queue_ticks(1'b0, $urandom_range(0, 1) == 1, $urandom_range(1, 3), no_gap);
    endfunction

    // Mostly well-formed ranging cycles with random timing, some noise and broken cycles.
    function automatic void queue_random_phase(input int unsigned budget);
        int unsigned limit;
        int unsigned target;
        int unsigned wait_n;
        int unsigned high_n;
        int unsigned pick;
        int unsigned k;
        logic        no_gap;
        limit  = range_cm * US_PER_CM_DEF;
        target = pending_ticks.size() + budget;
        while (pending_ticks.size() < target)
        begin
            pick   = $urandom_range(0, 99);
            no_gap = ($urandom_range(0, 3) == 0);
            if (pick < 10)
            begin
                // Noise: idle ticks with random echo and a stray start now and then.
                for (k = $urandom_range(4, 24); k != 0; k--)
                    queue_ticks($urandom_range(0, 15) == 0, $urandom_range(0, 1) == 1, 1, no_gap);
            end
            else if (pick < 18)
            begin
                // Broken cycle: echo is already high when the trigger pulse ends.
                queue_ranging(1'b1, 0, $urandom_range(0, 6), 1'b0, 1'b1, no_gap);
            end
            else
            begin
                wait_n = $urandom_range(0, 12);
                if (limit != 0 && limit <= 200 && $urandom_range(0, 2) == 0)
                    high_n = $urandom_range(limit > 2 ? limit - 2 : 1, limit + 2);
                else
                    high_n = $urandom_range(1, 70);
                queue_ranging(1'b0, wait_n, high_n, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0, no_gap);
            end
        end
    endfunction

    // Wait until every tick is sent, every result is in and the ranger is idle.
    task automatic await_idle();
        do
        begin
            @(negedge clk);
            while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(negedge clk);
            // A ranging cycle still running gets a short echo and low ticks until it ends.
            if (ranger_phase != PH_IDLE)
            begin
                queue_ticks(1'b0, 1'b1, 1, 1'b0);
                queue_ticks(1'b0, 1'b0, 15, 1'b0);
            end
        end
        while (ranger_phase != PH_IDLE);
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    // Write the range register and let the echo limit settle before the next tick.
    task automatic write_range(input logic [CFG_W-1:0] cm);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cm;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        range_cm = cm;
        repeat (CFG_SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // Tick driver: presents queued ticks and predicts the result of each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        tick_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_wait  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_ranger(s_tdata[0], s_tdata[1]));
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait != 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end
                else if (pending_ticks.size() != 0)
                begin
                    nxt = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W - 2){1'b0}}, nxt.echo_level, nxt.start_req};
                    tx_wait  <= nxt.no_gap ? 0 : $urandom_range(0, 5);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result checker: compares each result beat with the oldest prediction, stalls at random.
    always @(posedge clk or negedge rst_n)
    begin : result_checker
        result_t     got;
        result_t     want;
        int unsigned stall;
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            rx_wait        <= 0;
            rx_burst       <= 0;
            rx_hold_left   <= 0;
            rx_hold_served <= 0;
        end
        else
        begin
            stall = rx_wait;
            if (m_tvalid && m_tready)
            begin
                got          = result_t'(m_tdata[$bits(result_t)-1:0]);
                results_seen = results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: beat %h arrived with nothing predicted",
                                 results_seen, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.trigger_level != want.trigger_level || got.done_res != want.done_res ||
                        got.status != want.status ||
                        got.distance_sixteenths != want.distance_sixteenths)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result %0d: expected trig %0b done %0b status %0d ",
                                      "dist %0d, got trig %0b done %0b status %0d dist %0d"},
                                     results_seen, want.trigger_level, want.done_res,
                                     want.status, want.distance_sixteenths, got.trigger_level,
                                     got.done_res, got.status, got.distance_sixteenths);
                    end
                end
                // Stall before the next beat, except inside a burst of back-to-back beats or while quiet.
                stall = (rx_quiet || rx_burst != 0) ? 0 : $urandom_range(0, 5);
                if (rx_burst != 0)
                    rx_burst <= rx_burst - 1;
                else if ($urandom_range(0, 49) == 0)
                    rx_burst <= $urandom_range(20, 80);
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
                rx_wait      <= stall;
            end
            else if (rx_hold_asks != rx_hold_served)
            begin
                // Long hold-off so the pipeline fills and back-pressures the ticks.
                rx_hold_served <= rx_hold_served + 1;
                rx_hold_left   <= HOLD_CYCLES;
                m_tready       <= 1'b0;
                rx_wait        <= stall;
            end
            else if (stall != 0)
            begin
                rx_wait  <= stall - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_wait  <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("ultrasonic_echo_ranger test failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus: directed cases first, then random phases at several range settings.
    initial
    begin : stimulus
        logic [CFG_W-1:0] ranges [4];
        int unsigned      idx;
        ranges    = '{10'd1, 10'd23, 10'd2, 10'd0};
        ranges[3] = CFG_W'($urandom_range(0, 1000));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset range: idle echo, echo busy at the check, start held through whole cycles, then plain and stray cycles.
        queue_ticks(1'b0, 1'b0, 2, 1'b0);
        queue_ticks(1'b0, 1'b1, 2, 1'b0);
        queue_ranging(1'b1, 0, 0, 1'b1, 1'b0, 1'b0);
        queue_ranging(1'b0, 0, 1, 1'b1, 1'b0, 1'b0);
        queue_ranging(1'b0, 7, 58, 1'b0, 1'b0, 1'b1);
        queue_ranging(1'b0, 3, 100, 1'b0, 1'b1, 1'b0);
        // No echo at all: the wait runs out.
        queue_ranging(1'b0, ECHO_WAIT_US_DEF, 0, 1'b0, 1'b0, 1'b1);
        await_idle();

        // One centimetre: just inside, at and beyond the echo limit, without gaps.
        write_range(10'd1);
        rx_quiet = 1'b1;
        queue_ranging(1'b0, 2, US_PER_CM_DEF - 1, 1'b0, 1'b0, 1'b1);
        queue_ranging(1'b0, 2, US_PER_CM_DEF, 1'b0, 1'b0, 1'b1);
        queue_ranging(1'b0, 0, US_PER_CM_DEF + 1, 1'b0, 1'b0, 1'b1);
        await_idle();
        rx_quiet = 1'b0;

        // Zero range: the first high tick fails.
        write_range(10'd0);
        queue_ranging(1'b0, 1, 1, 1'b0, 1'b0, 1'b0);
        queue_ranging(1'b0, 0, 3, 1'b1, 1'b0, 1'b0);
        await_idle();

        // Random phases; the first one starts with a long receiver hold-off.
        for (idx = 0; idx < 4; idx++)
        begin
            write_range(ranges[idx]);
            queue_random_phase(PHASE_TICKS);
            if (idx == 0)
                rx_hold_asks = rx_hold_asks + 1;
            await_idle();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ultrasonic_echo_ranger test passed");
        else
            $display("ultrasonic_echo_ranger test failed");
        $finish;
    end

endmodule
